/* sv/tsmh_pkg.sv */
package tsmh_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;
    localparam int TS_W     = 64;

    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [TS_W-1:0]     ts_t;

    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_REMOVE = 2'd1;
    localparam kind_t KIND_GETMIN = 2'd2;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_UNUSED    = 2'd3;

endpackage

/* sv/timestamp_min_heap.sv */
// Channel   Dir  Handshake           Payload (lowest bit up)
// s_        in   s_tvalid/s_tready   tuser: kind[1:0]; tdata: timestamp[63:0]
// m_        out  m_tvalid/m_tready   tdata: status[1:0], min_value[65:2],
//                                           entry_count[72:66], zeros[79:73]
//
// One item at a time; the heap lives in a single memory with one write and one
// registered read port, so every step of a sift costs memory cycles.
// Get minimum or a rejected item goes straight to the done state. Insert sifts up
// with a parent read and a compare per level. Remove scans for the entry, sifts a
// zero up from its hole to the root, pops the last entry and sifts it down from the root.
// Reset clears the fill count, the state and both valid flags; no clearing pass is needed.
// A new item is taken while a result still waits; a stalled result holds the
// finished item in the done state until the result register frees.
module timestamp_min_heap (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tsmh_pkg::S_TDATA_W-1:0] s_tdata,   // timestamp[63:0]
    input  logic [tsmh_pkg::S_TUSER_W-1:0] s_tuser,   // kind[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tsmh_pkg::M_TDATA_W-1:0] m_tdata    // status[1:0], min_value[65:2],
                                                      // entry_count[72:66], zeros
);

    localparam int ADDR_W  = tsmh_pkg::ADDR_W;
    localparam int CNT_W   = tsmh_pkg::CNT_W;
    localparam int CHILD_W = tsmh_pkg::CHILD_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_UP_RD  = 4'd2;
    localparam logic [3:0] ST_UP_CMP = 4'd3;
    localparam logic [3:0] ST_POP_RD = 4'd4;
    localparam logic [3:0] ST_POP_LD = 4'd5;
    localparam logic [3:0] ST_DN_L   = 4'd6;
    localparam logic [3:0] ST_DN_R   = 4'd7;
    localparam logic [3:0] ST_DN_C   = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;

    // heap storage: one write port, one registered read port
    tsmh_pkg::ts_t heap_mem [tsmh_pkg::CAPACITY];
    tsmh_pkg::ts_t rdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    tsmh_pkg::ts_t     mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= heap_mem[mem_raddr];
        end
    end

    // control and working registers
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              rdv_reg, rdv_next;
    logic [ADDR_W-1:0] rdidx_reg, rdidx_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    tsmh_pkg::ts_t     cur_reg, cur_next;
    tsmh_pkg::ts_t     ts_reg, ts_next;
    tsmh_pkg::ts_t     lval_reg, lval_next;
    logic              rok_reg, rok_next;
    tsmh_pkg::kind_t   op_reg, op_next;
    tsmh_pkg::status_t status_reg, status_next;
    tsmh_pkg::ts_t     root_reg;
    logic              m_valid_reg, m_valid_next;
    logic [tsmh_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    // heap geometry around the current hole
    logic [ADDR_W-1:0]  pos_m1;
    logic [ADDR_W-1:0]  parent_idx;
    logic [CHILD_W-1:0] l_idx;
    logic [CHILD_W-1:0] r_idx;
    logic [CHILD_W-1:0] fill_wide;
    logic               l_ok;
    logic               r_ok;

    // sift-down choice
    logic               l_wins;
    tsmh_pkg::ts_t      best_val;
    logic               r_wins;

    assign pos_m1     = pos_reg - ADDR_W'(1);
    assign parent_idx = {1'b0, pos_m1[ADDR_W-1:1]};
    assign l_idx      = {1'b0, pos_reg, 1'b1};
    assign r_idx      = l_idx + CHILD_W'(1);
    assign fill_wide  = CHILD_W'(fill_reg);
    assign l_ok       = l_idx < fill_wide;
    assign r_ok       = r_idx < fill_wide;

    assign l_wins   = lval_reg < cur_reg;
    assign best_val = l_wins ? lval_reg : cur_reg;
    assign r_wins   = rok_reg && (rdata_reg < best_val);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        scan_next    = scan_reg;
        rdv_next     = rdv_reg;
        rdidx_next   = rdidx_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        ts_next      = ts_reg;
        lval_next    = lval_reg;
        rok_next     = rok_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = cur_reg;
        mem_re       = 1'b0;
        mem_raddr    = parent_idx;

        // drop the result once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = s_tuser;
                    ts_next     = s_tdata;
                    status_next = tsmh_pkg::STATUS_OK;
                    case (s_tuser)
                        tsmh_pkg::KIND_INSERT: begin
                            if (fill_reg >= CNT_W'(tsmh_pkg::CAPACITY)) begin
                                status_next = tsmh_pkg::STATUS_FULL;
                                state_next  = ST_DONE;
                            end else begin
                                // hole at the new tail, value rides in cur_reg
                                pos_next   = fill_reg[ADDR_W-1:0];
                                cur_next   = s_tdata;
                                fill_next  = fill_reg + CNT_W'(1);
                                state_next = ST_UP_RD;
                            end
                        end
                        tsmh_pkg::KIND_REMOVE: begin
                            if (fill_reg == '0) begin
                                status_next = tsmh_pkg::STATUS_NOT_FOUND;
                                state_next  = ST_DONE;
                            end else begin
                                scan_next  = '0;
                                rdv_next   = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            if (fill_reg == '0) begin
                                status_next = tsmh_pkg::STATUS_NOT_FOUND;
                            end
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // compare the entry read last cycle while fetching the next
                if (rdv_reg && (rdata_reg == ts_reg)) begin
                    pos_next   = rdidx_reg;
                    cur_next   = '0;
                    state_next = ST_UP_RD;
                end else if (scan_reg < fill_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = scan_reg[ADDR_W-1:0];
                    rdidx_next = scan_reg[ADDR_W-1:0];
                    rdv_next   = 1'b1;
                    scan_next  = scan_reg + CNT_W'(1);
                end else if (rdv_reg) begin
                    rdv_next = 1'b0;
                end else begin
                    status_next = tsmh_pkg::STATUS_NOT_FOUND;
                    state_next  = ST_DONE;
                end
            end

            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = (op_reg == tsmh_pkg::KIND_INSERT) ? ST_DONE : ST_POP_RD;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP: begin
                mem_we = 1'b1;
                if (rdata_reg > cur_reg) begin
                    // pull the parent down into the hole
                    mem_wdata  = rdata_reg;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = (op_reg == tsmh_pkg::KIND_INSERT) ? ST_DONE : ST_POP_RD;
                end
            end

            ST_POP_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(fill_reg - CNT_W'(1));
                fill_next  = fill_reg - CNT_W'(1);
                state_next = ST_POP_LD;
            end

            ST_POP_LD: begin
                cur_next   = rdata_reg;
                pos_next   = '0;
                state_next = (fill_reg == '0) ? ST_DONE : ST_DN_L;
            end

            ST_DN_L: begin
                if (l_ok) begin
                    mem_re     = 1'b1;
                    mem_raddr  = l_idx[ADDR_W-1:0];
                    state_next = ST_DN_R;
                end else begin
                    mem_we     = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_DN_R: begin
                lval_next = rdata_reg;
                rok_next  = r_ok;
                if (r_ok) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[ADDR_W-1:0];
                end
                state_next = ST_DN_C;
            end

            ST_DN_C: begin
                mem_we = 1'b1;
                if (r_wins) begin
                    mem_wdata  = rdata_reg;
                    pos_next   = r_idx[ADDR_W-1:0];
                    state_next = ST_DN_L;
                end else if (l_wins) begin
                    mem_wdata  = lval_reg;
                    pos_next   = l_idx[ADDR_W-1:0];
                    state_next = ST_DN_L;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {
                        {(tsmh_pkg::M_TDATA_W - tsmh_pkg::COUNT_OUT_W - tsmh_pkg::TS_W
                          - tsmh_pkg::STATUS_W){1'b0}},
                        tsmh_pkg::COUNT_OUT_W'(fill_reg),
                        (fill_reg == '0) ? '0 : root_reg,
                        status_reg
                    };
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // shadow copy of the root, kept in step with every write to entry zero
    always_ff @(posedge aclk) begin
        if (mem_we && (mem_waddr == '0)) begin
            root_reg <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            rdv_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            rdv_reg     <= rdv_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        rdidx_reg  <= rdidx_next;
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        ts_reg     <= ts_next;
        lval_reg   <= lval_next;
        rok_reg    <= rok_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* sv/tsmh_checker.sv */
module tsmh_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [tsmh_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [tsmh_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tsmh_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [1:0]  chk_status;
    logic [63:0] chk_min;
    logic [6:0]  chk_count;

    assign chk_status = m_tdata[1:0];
    assign chk_min    = m_tdata[65:2];
    assign chk_count  = m_tdata[72:66];

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> chk_status != tsmh_pkg::STATUS_UNUSED)
        else $error("undefined status code");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_count == 7'd0) |-> chk_min == 64'd0)
        else $error("empty heap reports a minimum");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_status == tsmh_pkg::STATUS_FULL)
            |-> chk_count == 7'(tsmh_pkg::CAPACITY))
        else $error("full status with room left");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is at work");

endmodule

bind timestamp_min_heap tsmh_checker u_tsmh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
